/* rtl/icds_pkg.sv */
// Package for the I2C serial clock divisor search unit.
// Holds the request, response, command and status types and the fixed constants.
// Depends on nothing; every other file in rtl but icds_div imports it.
package icds_pkg;

	// Field and datapath widths.
	localparam int unsigned CLK_W = 30;
	localparam int unsigned TGT_W = 20;
	localparam int unsigned DVS_W = 25;
	localparam int unsigned QUO_W = 26;
	localparam int unsigned ERR_W = 26;
	localparam int unsigned MUL_W = 11;
	localparam int unsigned ACT_W = 13;
	localparam int unsigned A_W   = 2;
	localparam int unsigned B_W   = 6;

	// Fixed constants of the divisor scheme.
	localparam logic [CLK_W-1:0] CLK_RESET  = 30'd112500000;
	localparam logic [4:0]       CLK_FACTOR = 5'd22;
	localparam logic [TGT_W-1:0] RATE_CAP   = 20'd384600;
	localparam logic [TGT_W-1:0] STD_HIGH   = 20'd100000;
	localparam logic [TGT_W-1:0] STD_SET    = 20'd90000;
	localparam int unsigned      B_COUNT    = 64;
	localparam int unsigned      A_MAX      = 3;

	// Status codes returned with each result.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_STARTED = 2'd1,
		ST_RANGE   = 2'd2
	} icds_status_t;

	// Operand selection for the shared divider.
	typedef enum logic [1:0] {
		DIV_BASE = 2'd0,
		DIV_A    = 2'd1,
		DIV_ACT  = 2'd2
	} icds_div_sel_t;

	typedef struct packed {
		logic [TGT_W-1:0] target_hz;
		logic             transfer_active;
	} icds_req_t;

	typedef struct packed {
		icds_status_t   status;
		logic [A_W-1:0] div_a;
		logic [B_W-1:0] div_b;
	} icds_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic          load;
		logic          div_go;
		icds_div_sel_t div_sel;
		logic          cap_quot;
		logic          clamp;
		logic          cap_limit;
		logic          pass_init;
		logic          cap_a;
		logic          upd_cand;
		logic          inc_b;
		logic          upd_best;
		logic          next_pass;
		logic          emit;
		icds_status_t  emit_status;
	} icds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;
		logic target_zero;
		logic quot_zero;
		logic a_ok;
		logic b_last;
		logic extra_pass;
		logic div_done;
	} icds_stat_t;

endpackage

/* rtl/icds_div.sv */
// Shared restoring divider, one quotient bit per clock.
// Generic in dividend and divisor widths; uses no package items.
module icds_div #(
	parameter int unsigned N_W = 30,
	parameter int unsigned D_W = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quo,
	output logic [D_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(N_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [D_W:0]     trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Control: run for one step per dividend bit, pulse done at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits as it drains.
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], fits};
			rem_q <= fits ? D_W'(trial - {1'b0, dvs_q}) : D_W'(trial);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

`ifndef NO_ASSERTIONS
	// A new division is never started on top of a running one.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !busy_q) else $error("divider restarted while busy");

	// The result is ready a fixed number of cycles after the start.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> ##(N_W + 1) done_q) else $error("divider latency wrong");

	// Completion only follows a running division.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q)) else $error("spurious divider done");
`endif

endmodule

/* rtl/icds_dp.sv */
// Datapath of the divisor search: clock register, search registers, result register.
// Depends on icds_pkg and instantiates icds_div.
module icds_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [icds_pkg::CLK_W-1:0]     cfg_data,
	input  icds_pkg::icds_req_t            req,
	input  icds_pkg::icds_cmd_t            cmd,
	output icds_pkg::icds_stat_t           stat,
	output icds_pkg::icds_rsp_t            rsp,
	output logic                           done
);

	import icds_pkg::*;

	localparam logic [B_W-1:0] B_LAST = B_W'(B_COUNT - 1);

	logic [CLK_W-1:0] clk_hz_q;
	logic [TGT_W-1:0] tgt_q;
	logic             active_q;
	logic [QUO_W-1:0] quot_q;
	logic             extra_q;
	logic [B_W-1:0]   b_q;
	logic [MUL_W-1:0] m22b_q;
	logic [A_W-1:0]   a_q;
	logic             a_ok_q;
	logic [ERR_W-1:0] last_err_q;
	logic [A_W-1:0]   cand_a_q;
	logic [B_W-1:0]   cand_b_q;
	logic [ERR_W-1:0] best_err_q;
	logic [A_W-1:0]   best_a_q;
	logic [B_W-1:0]   best_b_q;
	logic             done_q;
	icds_rsp_t        rsp_q;

	logic [TGT_W-1:0] tgt_clamped;
	logic [DVS_W-1:0] base_dvs;
	logic [ACT_W-1:0] act_dvs;
	logic [CLK_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [CLK_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;
	logic [ERR_W-1:0] actual;
	logic [ERR_W-1:0] tgt_ext;
	logic [ERR_W-1:0] err;

	// Input clock register, written through the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_we) begin
			clk_hz_q <= cfg_data;
		end
	end

	// Rate clamp: the fast-mode cap, and the standard-mode band pulled down.
	always_comb begin
		tgt_clamped = tgt_q;
		if (tgt_q > RATE_CAP) begin
			tgt_clamped = RATE_CAP;
		end else if (tgt_q <= STD_HIGH && tgt_q > STD_SET) begin
			tgt_clamped = STD_SET;
		end
	end

	// Divider operands: 22 times the target, quot over b+1, or 22*(a+1)*(b+1) from the stored 22*(b+1).
	assign base_dvs = DVS_W'(tgt_q) * DVS_W'(CLK_FACTOR);

	always_comb begin
		unique case (a_q)
			2'd0:    act_dvs = ACT_W'(m22b_q);
			2'd1:    act_dvs = ACT_W'({m22b_q, 1'b0});
			2'd2:    act_dvs = ACT_W'({m22b_q, 1'b0}) + ACT_W'(m22b_q);
			default: act_dvs = ACT_W'({m22b_q, 2'b00});
		endcase
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_A: begin
				div_dividend = CLK_W'(quot_q);
				div_divisor  = DVS_W'(b_q) + DVS_W'(1);
			end
			DIV_ACT: begin
				div_dividend = clk_hz_q;
				div_divisor  = DVS_W'(act_dvs);
			end
			default: begin
				div_dividend = clk_hz_q;
				div_divisor  = base_dvs;
			end
		endcase
	end

	icds_div #(
		.N_W(CLK_W),
		.D_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Error of the candidate rate against the clamped target.
	assign actual = ERR_W'(div_quo);
	assign tgt_ext = ERR_W'(tgt_q);
	assign err = (actual > tgt_ext) ? actual - tgt_ext : tgt_ext - actual;

	// Search registers, each updated on its own command.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q    <= req.target_hz;
			active_q <= req.transfer_active;
		end else if (cmd.clamp) begin
			tgt_q <= tgt_clamped;
		end

		if (cmd.cap_quot) begin
			quot_q <= QUO_W'(div_quo);
		end else if (cmd.next_pass) begin
			quot_q <= quot_q + QUO_W'(1);
		end

		if (cmd.cap_limit) begin
			extra_q <= div_rem != '0;
		end else if (cmd.next_pass) begin
			extra_q <= 1'b0;
		end

		if (cmd.pass_init) begin
			b_q    <= '0;
			m22b_q <= MUL_W'(CLK_FACTOR);
		end else if (cmd.inc_b) begin
			b_q    <= b_q + B_W'(1);
			m22b_q <= m22b_q + MUL_W'(CLK_FACTOR);
		end

		// First-stage divisor from quot/(b+1); it only qualifies up to A_MAX.
		if (cmd.cap_a) begin
			a_ok_q <= div_quo <= CLK_W'(A_MAX + 1);
			a_q    <= (div_quo == '0) ? '0 : A_W'(div_quo - CLK_W'(1));
		end

		if (cmd.pass_init) begin
			last_err_q <= tgt_ext;
			cand_a_q   <= '0;
			cand_b_q   <= '0;
		end else if (cmd.upd_cand && err < last_err_q) begin
			last_err_q <= err;
			cand_a_q   <= a_q;
			cand_b_q   <= b_q;
		end

		if (cmd.cap_limit) begin
			best_err_q <= tgt_ext;
			best_a_q   <= '0;
			best_b_q   <= '0;
		end else if (cmd.upd_best && last_err_q < best_err_q) begin
			best_err_q <= last_err_q;
			best_a_q   <= cand_a_q;
			best_b_q   <= cand_b_q;
		end
	end

	// Result strobe and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.status <= cmd.emit_status;
			rsp_q.div_a  <= (cmd.emit_status == ST_OK) ? best_a_q : '0;
			rsp_q.div_b  <= (cmd.emit_status == ST_OK) ? best_b_q : '0;
		end
	end

	assign stat.active      = active_q;
	assign stat.target_zero = tgt_q == '0;
	assign stat.quot_zero   = quot_q == '0;
	assign stat.a_ok        = a_ok_q;
	assign stat.b_last      = b_q == B_LAST;
	assign stat.extra_pass  = extra_q;
	assign stat.div_done    = div_done;

	assign rsp  = rsp_q;
	assign done = done_q;

endmodule

/* rtl/icds_ctrl.sv */
// Controller state machine that sequences the divisor search.
// Depends on icds_pkg; drives the datapath through icds_cmd_t.
module icds_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  icds_pkg::icds_stat_t stat,
	output icds_pkg::icds_cmd_t  cmd,
	output logic                 busy
);

	import icds_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_WAIT_Q,
		S_QCHK,
		S_REM,
		S_WAIT_R,
		S_PASS,
		S_ADIV,
		S_WAIT_A,
		S_ACHK,
		S_WAIT_ACT,
		S_UPD,
		S_NEXTB,
		S_PASSEND,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   take;

	assign take = start && !busy_q;

	// State register and registered busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_CHECK;
						busy_q  <= 1'b1;
					end
				end
				S_CHECK: begin
					if (stat.active || stat.target_zero) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_WAIT_Q;
					end
				end
				S_WAIT_Q: begin
					if (stat.div_done) begin
						state_q <= S_QCHK;
					end
				end
				S_QCHK: begin
					if (stat.quot_zero) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_REM;
					end
				end
				S_REM: state_q <= S_WAIT_R;
				S_WAIT_R: begin
					if (stat.div_done) begin
						state_q <= S_PASS;
					end
				end
				S_PASS: state_q <= S_ADIV;
				S_ADIV: state_q <= S_WAIT_A;
				S_WAIT_A: begin
					if (stat.div_done) begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: state_q <= stat.a_ok ? S_WAIT_ACT : S_NEXTB;
				S_WAIT_ACT: begin
					if (stat.div_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: state_q <= S_NEXTB;
				S_NEXTB: state_q <= stat.b_last ? S_PASSEND : S_ADIV;
				S_PASSEND: state_q <= stat.extra_pass ? S_PASS : S_EMIT;
				S_EMIT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Command decode from the current state and datapath status.
	always_comb begin
		cmd             = '0;
		cmd.div_sel     = DIV_BASE;
		cmd.emit_status = ST_OK;
		unique case (state_q)
			S_IDLE: cmd.load = take;
			S_CHECK: begin
				if (stat.active) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_STARTED;
				end else if (stat.target_zero) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_RANGE;
				end else begin
					cmd.div_go = 1'b1;
				end
			end
			S_WAIT_Q: cmd.cap_quot = stat.div_done;
			S_QCHK: begin
				if (stat.quot_zero) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_RANGE;
				end else begin
					cmd.clamp = 1'b1;
				end
			end
			S_REM: cmd.div_go = 1'b1;
			S_WAIT_R: cmd.cap_limit = stat.div_done;
			S_PASS: cmd.pass_init = 1'b1;
			S_ADIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_A;
			end
			S_WAIT_A: cmd.cap_a = stat.div_done;
			S_ACHK: begin
				cmd.div_go  = stat.a_ok;
				cmd.div_sel = DIV_ACT;
			end
			S_WAIT_ACT: cmd.div_sel = DIV_ACT;
			S_UPD: cmd.upd_cand = 1'b1;
			S_NEXTB: cmd.inc_b = !stat.b_last;
			S_PASSEND: begin
				cmd.upd_best  = 1'b1;
				cmd.next_pass = stat.extra_pass;
			end
			S_EMIT: cmd.emit = 1'b1;
			default: cmd.load = 1'b0;
		endcase
	end

	assign busy = busy_q;

`ifndef NO_ASSERTIONS
	// Busy mirrors the state register.
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != S_IDLE)) else $error("busy out of step with state");

	// Every result ends the request.
	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE) else $error("result without return to idle");

	// An accepted request always starts with the early checks.
	a_take_check: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q == S_CHECK) else $error("request not taken");

	// The divider is only started outside of its wait states.
	a_go_place: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |-> state_q != S_WAIT_Q && state_q != S_WAIT_R &&
			state_q != S_WAIT_A && state_q != S_WAIT_ACT)
		else $error("divider started while waiting");
`endif

endmodule

/* rtl/i2c_clock_divisor_search_unit.sv */
// Top level of the I2C serial clock two-stage divisor search unit.
// Depends on icds_pkg; instantiates icds_ctrl and icds_dp.
//
//   Channel   Handshake            Payload
//   request   start / busy         req  (icds_req_t: target_hz, transfer_active)
//   result    done (1-cycle pulse) rsp  (icds_rsp_t: status, div_a, div_b)
//   config    cfg_valid/cfg_ready  cfg_data (input clock in Hz)
//
// A request is taken when start is high and busy is low; done pulses once per request.
// A running transfer or a zero target is answered from the early check; a too-fast target after the base division.
// A full search is one or two passes of 64 steps on the one shared divider; a step divides
// twice, or once when the first stage is out of range.
// Reset is asynchronous and sets the input clock register to 112500000.
// Results are pulsed and cannot be held off; cfg_ready is high while idle.
module i2c_clock_divisor_search_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  icds_pkg::icds_req_t        req,
	output logic                       done,
	output icds_pkg::icds_rsp_t        rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [icds_pkg::CLK_W-1:0] cfg_data
);

	import icds_pkg::*;

	icds_cmd_t  cmd;
	icds_stat_t stat;
	logic       busy_w;

	icds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy_w)
	);

	icds_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp),
		.done     (done)
	);

	// Configuration is only taken between requests.
	assign cfg_ready = !busy_w;
	assign busy      = busy_w;

endmodule

/* tb/i2c_clock_divisor_search_unit_tb.sv */
// Testbench for the I2C serial clock two-stage divisor search unit.
// Sends target rates, predicts status and divisor pairs, and checks every result pulse.
// Depends on icds_pkg and the RTL under rtl; needs no other file.
`timescale 1ns / 1ps

module i2c_clock_divisor_search_unit_tb;
	import icds_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int unsigned GAP_PCT     = 18;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	icds_req_t            req;
	logic                 done;
	icds_rsp_t            rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CLK_W-1:0]     cfg_data;

	// Testbench copy of the input clock register.
	logic [CLK_W-1:0]     input_clock_hz;
	icds_rsp_t            expected_pairs[$];
	bit                   gaps_on;
	int unsigned          fail_count;
	int unsigned          requests_sent;
	int unsigned          searches_sent;
	int unsigned          results_checked;
	int unsigned          clock_settings;
	int unsigned          cycle_count;

	i2c_clock_divisor_search_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Free-running 100 MHz clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ends the run if the block stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("i2c_clock_divisor_search_unit: mismatch");
			$finish;
		end
	end

	// Works out the status and divisor pair for one request at a given input clock.
	function automatic icds_rsp_t divisor_pair(input logic [CLK_W-1:0] fin, input icds_req_t r);
		icds_rsp_t   res;
		logic [63:0] f_in;
		logic [63:0] fact;
		logic [63:0] tgt;
		logic [63:0] quot;
		logic [63:0] qlimit;
		logic [63:0] q;
		logic [63:0] best_err;
		logic [63:0] best_a;
		logic [63:0] best_b;
		logic [63:0] last_err;
		logic [63:0] cand_a;
		logic [63:0] cand_b;
		logic [63:0] bp1;
		logic [63:0] a;
		logic [63:0] actual;
		logic [63:0] err;
		res = '0;
		res.status = ST_OK;
		f_in = 64'(fin);
		fact = 64'(CLK_FACTOR);
		tgt = 64'(r.target_hz);
		best_a = 0;
		best_b = 0;
		if (r.transfer_active) begin
			res.status = ST_STARTED;
			return res;
		end
		if (tgt == 0) begin
			res.status = ST_RANGE;
			return res;
		end
		// The base quotient uses the target before clamping.
		quot = f_in / (fact * tgt);
		if (quot == 0) begin
			res.status = ST_RANGE;
			return res;
		end
		if (tgt > 64'(RATE_CAP))
			tgt = 64'(RATE_CAP);
		if (tgt <= 64'(STD_HIGH) && tgt > 64'(STD_SET))
			tgt = 64'(STD_SET);
		qlimit = ((f_in % (fact * tgt)) != 0) ? quot + 1 : quot;
		best_err = tgt;
		// One or two passes over all second-stage values; earlier pairs win ties.
		for (q = quot; q <= qlimit; q++) begin
			last_err = tgt;
			cand_a = 0;
			cand_b = 0;
			for (int b = 0; b < B_COUNT; b++) begin
				bp1 = 64'(b + 1);
				a = q / bp1;
				if (a != 0)
					a = a - 1;
				if (a <= 64'(A_MAX)) begin
					actual = f_in / (fact * (a + 1) * bp1);
					err = (actual > tgt) ? actual - tgt : tgt - actual;
					if (last_err > err) begin
						cand_a = a;
						cand_b = bp1 - 1;
						last_err = err;
					end
				end
			end
			if (last_err < best_err) begin
				best_err = last_err;
				best_a = cand_a;
				best_b = cand_b;
			end
		end
		res.div_a = best_a[A_W-1:0];
		res.div_b = best_b[B_W-1:0];
		return res;
	endfunction

	// Compares every result pulse with the oldest prediction.
	always @(posedge clk) begin
		icds_rsp_t want;
		if (arst_n && done) begin
			if (expected_pairs.size() == 0) begin
				$error("unexpected result: status %0d, div_a %0d, div_b %0d",
					rsp.status, rsp.div_a, rsp.div_b);
				fail_count++;
			end else begin
				want = expected_pairs.pop_front();
				results_checked++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.div_a !== want.div_a) begin
					$error("div_a: expected %0d, actual %0d", want.div_a, rsp.div_a);
					fail_count++;
				end
				if (rsp.div_b !== want.div_b) begin
					$error("div_b: expected %0d, actual %0d", want.div_b, rsp.div_b);
					fail_count++;
				end
			end
		end
	end

	// Presents one request, sometimes after a random gap, and waits until it is taken.
	task automatic send_request(input logic [TGT_W-1:0] tgt, input logic act);
		icds_req_t r;
		icds_rsp_t want;
		r.target_hz = tgt;
		r.transfer_active = act;
		if (gaps_on && $urandom_range(99) < GAP_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		want = divisor_pair(input_clock_hz, r);
		expected_pairs.push_back(want);
		requests_sent++;
		if (want.status == ST_OK)
			searches_sent++;
	endtask

	// Stops sending and waits until every predicted result has arrived.
	task automatic wait_for_results();
		start <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
	endtask

	// Writes the input clock register while the block is idle.
	task automatic write_input_clock(input logic [CLK_W-1:0] hz);
		wait_for_results();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= hz;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		input_clock_hz = hz;
		clock_settings++;
	endtask

	// Reset setting: clamping edges, rate extremes, zero target and a running transfer.
	task automatic test_reset_setting();
		send_request(20'd100000, 1'b0);
		send_request(20'd100001, 1'b0);
		send_request(20'd90001, 1'b0);
		send_request(20'd90000, 1'b0);
		send_request(20'd384600, 1'b0);
		send_request(20'd384601, 1'b0);
		send_request(20'd1000000, 1'b0);
		// A very slow target leaves no pair with a small enough first stage.
		send_request(20'd1, 1'b0);
		send_request(20'd524288, 1'b0);
		send_request(20'd0, 1'b0);
		send_request(20'd100000, 1'b1);
		send_request(20'd0, 1'b1);
	endtask

	// Input clock extremes, and a target too fast for the base quotient.
	task automatic test_clock_extremes();
		write_input_clock(30'd1);
		send_request(20'd1, 1'b0);
		send_request(20'd1000000, 1'b0);
		write_input_clock(30'd1000000000);
		send_request(20'd1000000, 1'b0);
		send_request(20'd1, 1'b0);
		send_request(20'd400000, 1'b0);
		send_request(20'd100000, 1'b0);
		write_input_clock(30'd20000000);
		send_request(20'd1000000, 1'b0);
		send_request(20'd909090, 1'b0);
	endtask

	// Random targets over several input clock settings, most of them full searches.
	task automatic test_random_searches();
		logic [CLK_W-1:0] hz;
		int unsigned      pick;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: hz = 30'd1000000000;
				3: hz = CLK_RESET;
				default: hz = CLK_W'($urandom_range(1, 1000000000));
			endcase
			write_input_clock(hz);
			// One phase runs back to back with no gaps at all.
			gaps_on = (phase != 3);
			for (int i = 0; i < 20; i++) begin
				pick = $urandom_range(99);
				if (pick < 10)
					send_request(TGT_W'($urandom_range(0, 1000000)), 1'b1);
				else if (pick < 30)
					send_request(TGT_W'($urandom_range(80000, 400000)), 1'b0);
				else if (pick < 40)
					send_request(TGT_W'($urandom_range(1, 5000)), 1'b0);
				else
					send_request(TGT_W'($urandom_range(1, 1000000)), 1'b0);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Main sequence: reset, directed tests, random tests, then the verdict.
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		input_clock_hz = CLK_RESET;
		gaps_on = 1'b1;
		fail_count = 0;
		requests_sent = 0;
		searches_sent = 0;
		results_checked = 0;
		clock_settings = 0;
		cycle_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_setting();
		test_clock_extremes();
		test_random_searches();

		wait_for_results();
		repeat (20) @(posedge clk);
		if (expected_pairs.size() != 0) begin
			$error("%0d results never arrived", expected_pairs.size());
			fail_count++;
		end
		$display("Checked %0d results for %0d requests (%0d full searches)",
			results_checked, requests_sent, searches_sent);
		$display("across %0d written input clock settings plus the reset value.",
			clock_settings);
		if (fail_count == 0) begin
			$display("i2c_clock_divisor_search_unit: match");
		end else begin
			$display("i2c_clock_divisor_search_unit: mismatch");
		end
		$finish;
	end

endmodule
